// ===== sv/cae_pkg.sv =====
package cae_pkg;

  // Character codes
  localparam logic [7:0] CHAR_NUL  = 8'h00;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_SP   = 8'h20;
  localparam logic [7:0] CHAR_SEMI = 8'h3B;
  localparam logic [7:0] CHAR_EQ   = 8'h3D;

  // Configuration port
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned LIMIT_W   = 5;
  localparam logic [CFG_IDX_W-1:0] REG_NAME_LIMIT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_LIMIT = CFG_IDX_W'(1);
  localparam logic [LIMIT_W-1:0]   LIMIT_RESET     = LIMIT_W'(31);

  // Store depth defaults
  localparam int unsigned DEF_NAME_CHARS  = 31;
  localparam int unsigned DEF_VALUE_CHARS = 31;

  typedef enum logic [2:0] {
    MODE_START      = 3'd0,
    MODE_NAME_LEAD  = 3'd1,
    MODE_NAME       = 3'd2,
    MODE_VALUE_LEAD = 3'd3,
    MODE_VALUE      = 3'd4,
    MODE_SKIP       = 3'd5,
    MODE_DONE       = 3'd6
  } line_mode_t;

  typedef enum logic [1:0] {
    ST_IDLE       = 2'd0,
    ST_EMIT_NAME  = 2'd1,
    ST_EMIT_VALUE = 2'd2
  } ctl_state_t;

  typedef enum logic [1:0] {
    SEL_NAME_CHAR  = 2'd0,
    SEL_NAME_TERM  = 2'd1,
    SEL_VALUE_CHAR = 2'd2,
    SEL_VALUE_TERM = 2'd3
  } out_sel_t;

  typedef struct packed {
    logic     accept;
    logic     out_load;
    out_sel_t sel;
    logic     idx_inc;
    logic     idx_clr;
  } ctl_cmd_t;

  typedef struct packed {
    logic emit_req;
    logic out_free;
    logic name_more;
    logic value_more;
  } dp_status_t;

endpackage

// ===== sv/cae_in_if.sv =====
interface cae_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, data_byte, end_of_stream, input ready);
  modport sink   (input valid, data_byte, end_of_stream, output ready);
endinterface

// ===== sv/cae_out_if.sv =====
interface cae_out_if;
  logic       valid;
  logic       ready;
  logic       part_kind;
  logic [7:0] out_char;
  logic       is_terminator;
  logic       last;

  modport source (output valid, part_kind, out_char, is_terminator, last, input ready);
  modport sink   (input valid, part_kind, out_char, is_terminator, last, output ready);
endinterface

// ===== sv/cae_cfg_if.sv =====
interface cae_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [cae_pkg::CFG_IDX_W-1:0] index;
  logic [cae_pkg::LIMIT_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/cae_ctrl.sv =====
module cae_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                items_valid,
  output logic                items_ready,
  input  cae_pkg::dp_status_t status,
  output cae_pkg::ctl_cmd_t   cmd
);

  cae_pkg::ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cae_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      cae_pkg::ST_IDLE: begin
        if (items_valid && status.emit_req) state_next = cae_pkg::ST_EMIT_NAME;
      end
      cae_pkg::ST_EMIT_NAME: begin
        if (status.out_free && !status.name_more) state_next = cae_pkg::ST_EMIT_VALUE;
      end
      cae_pkg::ST_EMIT_VALUE: begin
        if (status.out_free && !status.value_more) state_next = cae_pkg::ST_IDLE;
      end
      default: state_next = cae_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    items_ready  = 1'b0;
    cmd.accept   = 1'b0;
    cmd.out_load = 1'b0;
    cmd.sel      = cae_pkg::SEL_NAME_CHAR;
    cmd.idx_inc  = 1'b0;
    cmd.idx_clr  = 1'b0;
    unique case (state)
      cae_pkg::ST_IDLE: begin
        items_ready = 1'b1;
        cmd.accept  = items_valid;
        cmd.idx_clr = items_valid;
      end
      cae_pkg::ST_EMIT_NAME: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          if (status.name_more) begin
            cmd.sel     = cae_pkg::SEL_NAME_CHAR;
            cmd.idx_inc = 1'b1;
          end else begin
            cmd.sel     = cae_pkg::SEL_NAME_TERM;
            cmd.idx_clr = 1'b1;
          end
        end
      end
      cae_pkg::ST_EMIT_VALUE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          if (status.value_more) begin
            cmd.sel     = cae_pkg::SEL_VALUE_CHAR;
            cmd.idx_inc = 1'b1;
          end else begin
            cmd.sel     = cae_pkg::SEL_VALUE_TERM;
            cmd.idx_clr = 1'b1;
          end
        end
      end
      default: begin
        items_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== sv/cae_datapath.sv =====
module cae_datapath #(
  parameter int unsigned NAME_CHARS  = cae_pkg::DEF_NAME_CHARS,
  parameter int unsigned VALUE_CHARS = cae_pkg::DEF_VALUE_CHARS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [7:0]                    data_byte,
  input  logic                          end_of_stream,
  input  logic                          cfg_write,
  input  logic [cae_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cae_pkg::LIMIT_W-1:0]   cfg_data,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          out_kind,
  output logic [7:0]                    out_char,
  output logic                          out_term,
  output logic                          out_last,
  input  cae_pkg::ctl_cmd_t             cmd,
  output cae_pkg::dp_status_t           status
);

  localparam int unsigned NCW   = $clog2(NAME_CHARS + 1);
  localparam int unsigned VCW   = $clog2(VALUE_CHARS + 1);
  localparam int unsigned NIW   = (NAME_CHARS > 1) ? $clog2(NAME_CHARS) : 1;
  localparam int unsigned VIW   = (VALUE_CHARS > 1) ? $clog2(VALUE_CHARS) : 1;
  localparam int unsigned IDX_W = (NCW > VCW) ? NCW : VCW;

  logic [cae_pkg::LIMIT_W-1:0] name_limit, value_limit;

  cae_pkg::line_mode_t line_mode, line_mode_next;
  logic [7:0]     name_store  [NAME_CHARS];
  logic [7:0]     value_store [VALUE_CHARS];
  logic [NCW-1:0] name_count, name_trim_len, emit_name_len;
  logic [VCW-1:0] value_count, value_trim_len, emit_value_len;
  logic           line_not_empty;
  logic [IDX_W-1:0] idx;

  logic [5:0] name_lim, value_lim;
  logic       name_room, value_room;
  logic       is_cr, is_lf, is_nul, is_eq, is_sp;
  logic       line_end, byte_take, mode_emits;
  logic       keep_name, keep_value;
  logic       name_wr, value_wr;

  // Effective limits: smaller of register and store depth
  assign name_lim  = ({1'b0, name_limit} < 6'(NAME_CHARS)) ? {1'b0, name_limit} : 6'(NAME_CHARS);
  assign value_lim = ({1'b0, value_limit} < 6'(VALUE_CHARS)) ?
                     {1'b0, value_limit} : 6'(VALUE_CHARS);
  assign name_room  = 6'(name_count) < name_lim;
  assign value_room = 6'(value_count) < value_lim;

  assign is_cr  = data_byte == cae_pkg::CHAR_CR;
  assign is_lf  = data_byte == cae_pkg::CHAR_LF;
  assign is_nul = data_byte == cae_pkg::CHAR_NUL;
  assign is_eq  = data_byte == cae_pkg::CHAR_EQ;
  assign is_sp  = data_byte == cae_pkg::CHAR_SP;

  assign line_end  = cmd.accept && (end_of_stream || is_lf);
  assign byte_take = cmd.accept && !end_of_stream && !is_cr && !is_lf;

  assign mode_emits = (line_mode == cae_pkg::MODE_VALUE_LEAD) ||
                      (line_mode == cae_pkg::MODE_VALUE) ||
                      (line_mode == cae_pkg::MODE_DONE);

  // Next line mode for a content byte
  always_comb begin
    line_mode_next = line_mode;
    unique case (line_mode)
      cae_pkg::MODE_START: begin
        line_mode_next = (data_byte == cae_pkg::CHAR_SEMI) ?
                         cae_pkg::MODE_NAME_LEAD : cae_pkg::MODE_SKIP;
      end
      cae_pkg::MODE_NAME_LEAD: begin
        priority if (is_nul) line_mode_next = cae_pkg::MODE_SKIP;
        else if (is_eq)      line_mode_next = cae_pkg::MODE_VALUE_LEAD;
        else if (!is_sp)     line_mode_next = cae_pkg::MODE_NAME;
        else                 line_mode_next = line_mode;
      end
      cae_pkg::MODE_NAME: begin
        priority if (is_nul) line_mode_next = cae_pkg::MODE_SKIP;
        else if (is_eq)      line_mode_next = cae_pkg::MODE_VALUE_LEAD;
        else                 line_mode_next = line_mode;
      end
      cae_pkg::MODE_VALUE_LEAD: begin
        priority if (is_nul) line_mode_next = cae_pkg::MODE_DONE;
        else if (!is_sp)     line_mode_next = cae_pkg::MODE_VALUE;
        else                 line_mode_next = line_mode;
      end
      cae_pkg::MODE_VALUE: begin
        if (is_nul) line_mode_next = cae_pkg::MODE_DONE;
      end
      cae_pkg::MODE_SKIP, cae_pkg::MODE_DONE: begin
        line_mode_next = line_mode;
      end
      default: line_mode_next = cae_pkg::MODE_SKIP;
    endcase
  end

  // Which store takes the byte
  always_comb begin
    keep_name  = 1'b0;
    keep_value = 1'b0;
    unique case (line_mode)
      cae_pkg::MODE_NAME_LEAD:  keep_name  = !is_nul && !is_eq && !is_sp;
      cae_pkg::MODE_NAME:       keep_name  = !is_nul && !is_eq;
      cae_pkg::MODE_VALUE_LEAD: keep_value = !is_nul && !is_sp;
      cae_pkg::MODE_VALUE:      keep_value = !is_nul;
      default: begin
        keep_name  = 1'b0;
        keep_value = 1'b0;
      end
    endcase
  end

  assign name_wr  = byte_take && keep_name && name_room;
  assign value_wr = byte_take && keep_value && value_room;

  always_ff @(posedge clk) begin
    if (name_wr) name_store[name_count[NIW-1:0]] <= data_byte;
    if (value_wr) value_store[value_count[VIW-1:0]] <= data_byte;
    if (line_end) begin
      emit_name_len  <= name_trim_len;
      emit_value_len <= value_trim_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      name_limit     <= cae_pkg::LIMIT_RESET;
      value_limit    <= cae_pkg::LIMIT_RESET;
      line_mode      <= cae_pkg::MODE_START;
      name_count     <= '0;
      name_trim_len  <= '0;
      value_count    <= '0;
      value_trim_len <= '0;
      line_not_empty <= 1'b0;
    end else begin
      if (cfg_write && cfg_index == cae_pkg::REG_NAME_LIMIT) name_limit <= cfg_data;
      if (cfg_write && cfg_index == cae_pkg::REG_VALUE_LIMIT) value_limit <= cfg_data;
      if (line_end) begin
        line_mode      <= cae_pkg::MODE_START;
        name_count     <= '0;
        name_trim_len  <= '0;
        value_count    <= '0;
        value_trim_len <= '0;
        line_not_empty <= 1'b0;
      end else if (byte_take) begin
        line_not_empty <= 1'b1;
        line_mode      <= line_mode_next;
        if (name_wr) begin
          name_count <= name_count + NCW'(1);
          if (!is_sp) name_trim_len <= name_count + NCW'(1);
        end
        if (value_wr) begin
          value_count <= value_count + VCW'(1);
          if (!is_sp) value_trim_len <= value_count + VCW'(1);
        end
      end
    end
  end

  // Emission index
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + IDX_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      unique case (cmd.sel)
        cae_pkg::SEL_NAME_CHAR: begin
          out_kind <= 1'b0;
          out_char <= name_store[idx[NIW-1:0]];
          out_term <= 1'b0;
          out_last <= 1'b0;
        end
        cae_pkg::SEL_NAME_TERM: begin
          out_kind <= 1'b0;
          out_char <= cae_pkg::CHAR_NUL;
          out_term <= 1'b1;
          out_last <= 1'b0;
        end
        cae_pkg::SEL_VALUE_CHAR: begin
          out_kind <= 1'b1;
          out_char <= value_store[idx[VIW-1:0]];
          out_term <= 1'b0;
          out_last <= 1'b0;
        end
        cae_pkg::SEL_VALUE_TERM: begin
          out_kind <= 1'b1;
          out_char <= cae_pkg::CHAR_NUL;
          out_term <= 1'b1;
          out_last <= 1'b1;
        end
        default: begin
          out_kind <= 1'b0;
          out_char <= cae_pkg::CHAR_NUL;
          out_term <= 1'b0;
          out_last <= 1'b0;
        end
      endcase
    end
  end

  assign status.emit_req   = (end_of_stream ? line_not_empty : is_lf) && mode_emits;
  assign status.out_free   = !out_valid || out_ready;
  assign status.name_more  = idx < IDX_W'(emit_name_len);
  assign status.value_more = idx < IDX_W'(emit_value_len);

endmodule

// ===== sv/comment_assignment_extractor.sv =====
// Channel   Dir   Payload                                    Handshake
// items     in    data_byte[7:0], end_of_stream              valid/ready
// results   out   part_kind, out_char[7:0], is_terminator,   valid/ready
//                 last
// cfg       in    index[3:0], data[4:0]                      valid/ready, ready always 1
//
// Flow: an ordinary byte, CR or a line end with nothing to report is taken
// at once. A reported line end is taken, then its results (name chars + 1 + value
// chars + 1) leave the single output register one per cycle while results.ready=1.
// Reset: synchronous rst clears the parser to line start and both limits to 31;
// store contents are not cleared (only entries of the current line are read).
// Stalls: results sit in an output register; the next byte is taken while the
// value terminator still waits there. items.ready is low during a burst.
module comment_assignment_extractor #(
  parameter int unsigned NAME_CHARS  = cae_pkg::DEF_NAME_CHARS,
  parameter int unsigned VALUE_CHARS = cae_pkg::DEF_VALUE_CHARS
) (
  input logic      clk,
  input logic      rst,
  cae_in_if.sink   items,
  cae_out_if.source results,
  cae_cfg_if.sink  cfg
);

  cae_pkg::ctl_cmd_t   cmd;
  cae_pkg::dp_status_t status;
  logic                items_ready;

  // Limits are plain registers; a write takes effect in the next cycle
  assign cfg.ready   = 1'b1;
  assign items.ready = items_ready;

  cae_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .items_valid (items.valid),
    .items_ready (items_ready),
    .status      (status),
    .cmd         (cmd)
  );

  cae_datapath #(
    .NAME_CHARS  (NAME_CHARS),
    .VALUE_CHARS (VALUE_CHARS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .data_byte     (items.data_byte),
    .end_of_stream (items.end_of_stream),
    .cfg_write     (cfg.valid),
    .cfg_index     (cfg.index),
    .cfg_data      (cfg.data),
    .out_ready     (results.ready),
    .out_valid     (results.valid),
    .out_kind      (results.part_kind),
    .out_char      (results.out_char),
    .out_term      (results.is_terminator),
    .out_last      (results.last),
    .cmd           (cmd),
    .status        (status)
  );

endmodule
